// ===== rtl/wrs_pkg.sv =====
// wrs_pkg: shared constants, datapath command/status types and controller states
// for the wilder rsi stream block; used by every rtl file but wrs_div, depends on nothing
`default_nettype none

package wrs_pkg;

    localparam int PRICE_W        = 32;
    localparam int RSI_W          = 14;
    localparam int PERIOD_W       = 8;
    localparam int AVG_BITS       = 48;
    localparam int PRICE_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    localparam logic [PERIOD_W-1:0] PERIOD_RST = 8'd14;
    localparam logic [PERIOD_W-1:0] PERIOD_MIN = 8'd2;
    localparam logic [RSI_W-1:0]    RSI_SCALE  = 14'd10000;
    localparam logic [RSI_W-1:0]    RSI_FLAT   = 14'd5000;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_DELTA,
        OP_SUM,
        OP_MUL,
        OP_PREP_INIT,
        OP_PREP_SMOOTH,
        OP_PREP_RSI,
        OP_DIV_P,
        OP_DIV_RSI,
        OP_STORE,
        OP_OUT
    } t_dp_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DELTA,
        ST_SUM,
        ST_MUL,
        ST_PREP,
        ST_DIV,
        ST_WAIT,
        ST_STORE,
        ST_RSI_PREP,
        ST_RSI_DIV,
        ST_RSI_WAIT,
        ST_OUT
    } t_state;

    typedef struct packed {
        t_dp_op op;
        logic   side;       // 0 gain, 1 loss
    } t_dp_cmd;

    typedef struct packed {
        logic first;
        logic warm;
        logic cnt_lt_p;
        logic flat;
        logic no_loss;
        logic div_busy;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== rtl/wilder_rsi_stream_top.sv =====
// wilder rsi stream: one price per input transfer, wilder rsi per result transfer
// top level joining wrs_ctrl and wrs_dp; depends on wrs_pkg
//
// input channel i_valid/o_ready carries i_price; output channel o_valid/i_ready
// carries o_price_echo, o_rsi_value (hundredths of a percent) and o_flat_flag.
// i_period_we/i_period writes the averaging period; the user writes it only
// while idle, the block itself does not enforce this. the first price after
// reset only sets the reference; the next period prices are summed, and the
// last of them completes warm-up; from that price on, each price gives one result.
// one price is worked at a time. a price with a result raises o_valid once the
// shared one-bit-per-cycle divider has done two 48-step divisions by the period
// and a 14-step ratio division, the ratio division skipped when flat or without
// loss; o_ready returns in the cycle o_valid rises.
// while the receiver stalls, the result holds and the next price is still
// taken; the block waits only when a second result is ready with the first
// not yet transferred.
// synchronous reset clears the averages, the count, the output valid and sets
// the period to 14.
`default_nettype none

module wilder_rsi_stream_top #(
    parameter int PRICE_BITS = wrs_pkg::PRICE_BITS_DEF,
    parameter int FRAC_BITS  = wrs_pkg::FRAC_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [wrs_pkg::PRICE_W-1:0]  i_price,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [wrs_pkg::PRICE_W-1:0]       o_price_echo,
    output logic [wrs_pkg::RSI_W-1:0]         o_rsi_value,
    output logic                              o_flat_flag,
    input  wire logic                         i_period_we,
    input  wire logic [wrs_pkg::PERIOD_W-1:0] i_period
);

    wrs_pkg::t_dp_cmd cmd;
    wrs_pkg::t_dp_sts sts;

    wrs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    wrs_dp #(
        .PRICE_BITS (PRICE_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_period_we  (i_period_we),
        .i_period     (i_period),
        .i_price      (i_price),
        .i_ready      (i_ready),
        .o_valid      (o_valid),
        .o_price_echo (o_price_echo),
        .o_rsi_value  (o_rsi_value),
        .o_flat_flag  (o_flat_flag)
    );

endmodule

`default_nettype wire

// ===== rtl/wrs_div.sv =====
// wrs_div: shared radix-2 restoring divider, one quotient bit per cycle
// depends on nothing; driven by wrs_dp
`default_nettype none

module wrs_div #(
    parameter int QUO_W = 48,
    parameter int DEN_W = 49,
    parameter int CNT_W = 6
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [CNT_W-1:0] i_steps,
    input  wire logic [DEN_W-1:0] i_rem_init,
    input  wire logic [QUO_W-1:0] i_qr_init,
    input  wire logic [DEN_W-1:0] i_den,
    output logic                  o_busy,
    output logic [QUO_W-1:0]      o_quot
);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [QUO_W-1:0] r_qr;
    logic [DEN_W-1:0] r_den;

    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           fits;

    always_comb begin
        trial = {r_rem, r_qr[QUO_W-1]};
        diff  = trial - {1'b0, r_den};
        fits  = trial >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= i_steps;
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_rem_init;
            r_qr  <= i_qr_init;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            r_qr  <= {r_qr[QUO_W-2:0], fits};
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_qr;

endmodule

`default_nettype wire

// ===== rtl/wrs_dp.sv =====
// wrs_dp: datapath with price state, gain/loss averages, period register,
// multipliers, output register and the shared divider; depends on wrs_pkg, wrs_div
`default_nettype none

module wrs_dp #(
    parameter int PRICE_BITS = wrs_pkg::PRICE_BITS_DEF,
    parameter int FRAC_BITS  = wrs_pkg::FRAC_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire wrs_pkg::t_dp_cmd                i_cmd,
    output wrs_pkg::t_dp_sts                     o_sts,
    input  wire logic                            i_period_we,
    input  wire logic [wrs_pkg::PERIOD_W-1:0]    i_period,
    input  wire logic [wrs_pkg::PRICE_W-1:0]     i_price,
    input  wire logic                            i_ready,
    output logic                                 o_valid,
    output logic [wrs_pkg::PRICE_W-1:0]          o_price_echo,
    output logic [wrs_pkg::RSI_W-1:0]            o_rsi_value,
    output logic                                 o_flat_flag
);

    localparam int AVG_W  = wrs_pkg::AVG_BITS;
    localparam int PER_W  = wrs_pkg::PERIOD_W;
    localparam int RSI_W  = wrs_pkg::RSI_W;
    localparam int PROD_W = AVG_W + PER_W;
    localparam int PRS_W  = AVG_W + RSI_W;
    localparam int NUM_W  = (FRAC_BITS > RSI_W) ? AVG_W + FRAC_BITS : PRS_W;
    localparam int DEN_W  = AVG_W + 1;
    localparam int CNT_W  = $clog2(AVG_W + 1);
    localparam logic [AVG_W-1:0] AVG_MAX = '1;

    function automatic logic [AVG_W-1:0] sat_add(input logic [AVG_W-1:0] a,
                                                 input logic [AVG_W-1:0] b);
        logic [AVG_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[AVG_W] ? AVG_MAX : s[AVG_W-1:0];
    endfunction

    // model state and control
    logic [PER_W-1:0]      r_period;
    logic [PRICE_BITS-1:0] r_prev;
    logic [PER_W-1:0]      r_count;
    logic                  r_warm;
    logic [AVG_W-1:0]      r_avg_gain;
    logic [AVG_W-1:0]      r_avg_loss;
    logic                  r_out_valid;

    // working registers
    logic [PRICE_BITS-1:0] r_price;
    logic [PRICE_BITS-1:0] r_gain;
    logic [PRICE_BITS-1:0] r_loss;
    logic [PROD_W-1:0]     r_prod;
    logic [NUM_W-1:0]      r_num;
    logic [DEN_W-1:0]      r_den;
    logic                  r_sat;
    logic [wrs_pkg::PRICE_W-1:0] r_out_price;
    logic [RSI_W-1:0]      r_out_rsi;
    logic                  r_out_flat;

    logic [PER_W-1:0]      p;
    logic [AVG_W-1:0]      avg_sel;
    logic [PRICE_BITS-1:0] delta_sel;
    logic [AVG_W-1:0]      x_fixed;
    logic                  init_sat;
    logic                  up;
    logic                  first;
    logic                  cnt_lt_p;
    logic                  flat;
    logic                  no_loss;
    logic [PRS_W-1:0]      rsi_prod;
    logic [RSI_W-1:0]      rsi_sel;

    logic                  div_start;
    logic [CNT_W-1:0]      div_steps;
    logic [DEN_W-1:0]      div_rem_init;
    logic [AVG_W-1:0]      div_qr_init;
    logic [DEN_W-1:0]      div_den;
    logic                  div_busy;
    logic [AVG_W-1:0]      div_quot;

    always_comb begin
        p         = (r_period < wrs_pkg::PERIOD_MIN) ? wrs_pkg::PERIOD_MIN : r_period;
        avg_sel   = i_cmd.side ? r_avg_loss : r_avg_gain;
        delta_sel = i_cmd.side ? r_loss : r_gain;
        x_fixed   = ((delta_sel >> (AVG_W - FRAC_BITS)) != '0)
                  ? AVG_MAX : (AVG_W'(delta_sel) << FRAC_BITS);
        init_sat  = (avg_sel >> (AVG_W - FRAC_BITS)) >= AVG_W'(p);
        up        = r_price > r_prev;
        first     = (r_count == '0) && !r_warm;
        cnt_lt_p  = r_count < p;
        flat      = (r_avg_gain == '0) && (r_avg_loss == '0);
        no_loss   = r_avg_loss == '0;
        rsi_prod  = PRS_W'(r_avg_gain) * PRS_W'(wrs_pkg::RSI_SCALE);
        rsi_sel   = flat ? wrs_pkg::RSI_FLAT
                  : (no_loss ? wrs_pkg::RSI_SCALE : div_quot[RSI_W-1:0]);
    end

    // divider operand selection
    always_comb begin
        div_start    = 1'b0;
        div_steps    = CNT_W'(AVG_W);
        div_rem_init = DEN_W'(r_num >> AVG_W);
        div_qr_init  = r_num[AVG_W-1:0];
        div_den      = DEN_W'(p);
        case (i_cmd.op)
            wrs_pkg::OP_DIV_P: begin
                div_start = 1'b1;
            end
            wrs_pkg::OP_DIV_RSI: begin
                div_start    = 1'b1;
                div_steps    = CNT_W'(RSI_W);
                div_rem_init = DEN_W'(r_num >> RSI_W);
                div_qr_init  = AVG_W'(r_num[RSI_W-1:0]) << (AVG_W - RSI_W);
                div_den      = r_den;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period    <= wrs_pkg::PERIOD_RST;
            r_prev      <= '0;
            r_count     <= '0;
            r_warm      <= 1'b0;
            r_avg_gain  <= '0;
            r_avg_loss  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_period_we) begin
                r_period <= i_period;
            end
            if (i_cmd.op == wrs_pkg::OP_OUT) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (i_cmd.op)
                wrs_pkg::OP_DELTA: begin
                    r_prev <= r_price;
                    if (first) begin
                        r_count <= PER_W'(1);
                    end
                end
                wrs_pkg::OP_SUM: begin
                    r_avg_gain <= sat_add(r_avg_gain, AVG_W'(r_gain));
                    r_avg_loss <= sat_add(r_avg_loss, AVG_W'(r_loss));
                    if (cnt_lt_p) begin
                        r_count <= r_count + PER_W'(1);
                    end
                end
                wrs_pkg::OP_STORE: begin
                    if (i_cmd.side) begin
                        r_avg_loss <= r_sat ? AVG_MAX : div_quot;
                    end else begin
                        r_avg_gain <= r_sat ? AVG_MAX : div_quot;
                    end
                end
                wrs_pkg::OP_PREP_RSI: begin
                    r_warm <= 1'b1;
                end
                default: begin
                    r_warm <= r_warm;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            wrs_pkg::OP_LOAD: begin
                r_price <= PRICE_BITS'(i_price);
            end
            wrs_pkg::OP_DELTA: begin
                r_gain <= up ? r_price - r_prev : '0;
                r_loss <= up ? '0 : r_prev - r_price;
            end
            wrs_pkg::OP_MUL: begin
                r_prod <= PROD_W'(avg_sel) * PROD_W'(p - PER_W'(1));
            end
            wrs_pkg::OP_PREP_INIT: begin
                r_num <= NUM_W'(avg_sel) << FRAC_BITS;
                r_sat <= init_sat;
            end
            wrs_pkg::OP_PREP_SMOOTH: begin
                r_num <= NUM_W'(r_prod) + NUM_W'(x_fixed);
                r_sat <= 1'b0;
            end
            wrs_pkg::OP_PREP_RSI: begin
                r_num <= NUM_W'(rsi_prod);
                r_den <= {1'b0, r_avg_gain} + {1'b0, r_avg_loss};
            end
            wrs_pkg::OP_OUT: begin
                r_out_price <= wrs_pkg::PRICE_W'(r_price);
                r_out_rsi   <= rsi_sel;
                r_out_flat  <= flat;
            end
            default: begin
                r_sat <= r_sat;
            end
        endcase
    end

    wrs_div #(
        .QUO_W (AVG_W),
        .DEN_W (DEN_W),
        .CNT_W (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_steps    (div_steps),
        .i_rem_init (div_rem_init),
        .i_qr_init  (div_qr_init),
        .i_den      (div_den),
        .o_busy     (div_busy),
        .o_quot     (div_quot)
    );

    always_comb begin
        o_sts.first    = first;
        o_sts.warm     = r_warm;
        o_sts.cnt_lt_p = cnt_lt_p;
        o_sts.flat     = flat;
        o_sts.no_loss  = no_loss;
        o_sts.div_busy = div_busy;
        o_sts.out_free = !r_out_valid || i_ready;
    end

    assign o_valid      = r_out_valid;
    assign o_price_echo = r_out_price;
    assign o_rsi_value  = r_out_rsi;
    assign o_flat_flag  = r_out_flat;

endmodule

`default_nettype wire

// ===== rtl/wrs_ctrl.sv =====
// wrs_ctrl: controller state machine sequencing warm-up, smoothing and the
// rsi ratio through the datapath; depends on wrs_pkg
`default_nettype none

module wrs_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire wrs_pkg::t_dp_sts i_sts,
    output wrs_pkg::t_dp_cmd      o_cmd
);

    wrs_pkg::t_state r_state;
    wrs_pkg::t_state n_state;
    logic            r_side;
    logic            n_side;
    logic            r_init;
    logic            n_init;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wrs_pkg::ST_IDLE;
            r_side  <= 1'b0;
            r_init  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_side  <= n_side;
            r_init  <= n_init;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_side     = r_side;
        n_init     = r_init;
        o_ready    = 1'b0;
        o_cmd.op   = wrs_pkg::OP_NONE;
        o_cmd.side = r_side;
        case (r_state)
            wrs_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.op = wrs_pkg::OP_LOAD;
                    n_state  = wrs_pkg::ST_DELTA;
                end
            end
            wrs_pkg::ST_DELTA: begin
                o_cmd.op = wrs_pkg::OP_DELTA;
                n_side   = 1'b0;
                if (i_sts.first) begin
                    n_state = wrs_pkg::ST_IDLE;
                end else if (i_sts.warm) begin
                    n_init  = 1'b0;
                    n_state = wrs_pkg::ST_MUL;
                end else begin
                    n_state = wrs_pkg::ST_SUM;
                end
            end
            wrs_pkg::ST_SUM: begin
                o_cmd.op = wrs_pkg::OP_SUM;
                if (i_sts.cnt_lt_p) begin
                    n_state = wrs_pkg::ST_IDLE;
                end else begin
                    n_init  = 1'b1;
                    n_state = wrs_pkg::ST_PREP;
                end
            end
            wrs_pkg::ST_MUL: begin
                o_cmd.op = wrs_pkg::OP_MUL;
                n_state  = wrs_pkg::ST_PREP;
            end
            wrs_pkg::ST_PREP: begin
                o_cmd.op = r_init ? wrs_pkg::OP_PREP_INIT : wrs_pkg::OP_PREP_SMOOTH;
                n_state  = wrs_pkg::ST_DIV;
            end
            wrs_pkg::ST_DIV: begin
                o_cmd.op = wrs_pkg::OP_DIV_P;
                n_state  = wrs_pkg::ST_WAIT;
            end
            wrs_pkg::ST_WAIT: begin
                if (!i_sts.div_busy) begin
                    n_state = wrs_pkg::ST_STORE;
                end
            end
            wrs_pkg::ST_STORE: begin
                o_cmd.op = wrs_pkg::OP_STORE;
                if (!r_side) begin
                    n_side  = 1'b1;
                    n_state = r_init ? wrs_pkg::ST_PREP : wrs_pkg::ST_MUL;
                end else begin
                    n_state = wrs_pkg::ST_RSI_PREP;
                end
            end
            wrs_pkg::ST_RSI_PREP: begin
                o_cmd.op = wrs_pkg::OP_PREP_RSI;
                if (i_sts.flat || i_sts.no_loss) begin
                    n_state = wrs_pkg::ST_OUT;
                end else begin
                    n_state = wrs_pkg::ST_RSI_DIV;
                end
            end
            wrs_pkg::ST_RSI_DIV: begin
                o_cmd.op = wrs_pkg::OP_DIV_RSI;
                n_state  = wrs_pkg::ST_RSI_WAIT;
            end
            wrs_pkg::ST_RSI_WAIT: begin
                if (!i_sts.div_busy) begin
                    n_state = wrs_pkg::ST_OUT;
                end
            end
            wrs_pkg::ST_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.op = wrs_pkg::OP_OUT;
                    n_state  = wrs_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = wrs_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/wrs_chk.sv =====
// wrs_chk: port-level assertions for wilder_rsi_stream_top and the bind that
// attaches them; depends on wrs_pkg
`default_nettype none

module wrs_chk (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_in_valid,
    input wire logic                         i_in_ready,
    input wire logic                         i_out_valid,
    input wire logic                         i_out_ready,
    input wire logic [wrs_pkg::PRICE_W-1:0]  i_price_echo,
    input wire logic [wrs_pkg::RSI_W-1:0]    i_rsi_value,
    input wire logic                         i_flat_flag
);

    // reset empties the output register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    a_rsi_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_rsi_value <= wrs_pkg::RSI_SCALE)
        else $error("rsi above full scale");

    a_flat_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_flat_flag |-> i_rsi_value == wrs_pkg::RSI_FLAT)
        else $error("flat flag without mid value");

    // one price in work at a time
    a_single_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("ready right after a transfer");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_price_echo)
            && $stable(i_rsi_value) && $stable(i_flat_flag))
        else $error("stalled result changed");

endmodule

bind wilder_rsi_stream_top wrs_chk u_wrs_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_valid),
    .i_in_ready   (o_ready),
    .i_out_valid  (o_valid),
    .i_out_ready  (i_ready),
    .i_price_echo (o_price_echo),
    .i_rsi_value  (o_rsi_value),
    .i_flat_flag  (o_flat_flag)
);

`default_nettype wire
